/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/mbdeq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbdeq_pkg
// shared constants and types of the button debouncer with event queue
// ----------------------------------------------------------------------------
package mbdeq_pkg;

    // block sizing
    localparam int NUM_INPUTS  = 8;
    localparam int QUEUE_DEPTH = 32;

    // field widths
    localparam int PIN_W   = 8;
    localparam int TICK_W  = 8;
    localparam int EVIDX_W = 3;
    localparam int DROP_W  = 4;

    // derived widths
    localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    // constants
    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(20);
    localparam logic [TICK_W-1:0] SINCE_MAX      = {TICK_W{1'b1}};
    localparam logic [DROP_W-1:0] DROP_MAX       = {DROP_W{1'b1}};

    // input command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // one queued event
    typedef struct packed {
        logic [EVIDX_W-1:0] ev_index;
        logic               ev_pressed;
    } t_event;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic pop;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_idx;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

/* src/mbdeq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbdeq_ctrl
// sequencer: accepts a word, walks the inputs or pops, then hands off result
// ----------------------------------------------------------------------------
module mbdeq_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_cmd,
    output logic                   o_in_ready,
    output mbdeq_pkg::t_dp_cmd     o_cmd,
    input  mbdeq_pkg::t_dp_sts     i_sts
);
    import mbdeq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_POP    = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.start = 1'b1;
                    n_state     = (i_cmd == CMD_POP) ? S_POP : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_idx) begin
                    n_state = S_RESULT;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* src/mbdeq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbdeq_datapath
// per-input debounce state, event ring, result staging and output register
// ----------------------------------------------------------------------------
module mbdeq_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  mbdeq_pkg::t_dp_cmd               i_cmd,
    output mbdeq_pkg::t_dp_sts               o_sts,
    input  wire [mbdeq_pkg::PIN_W-1:0]       i_pin_levels,
    input  wire                              i_cfg_valid,
    input  wire [mbdeq_pkg::TICK_W-1:0]      i_cfg_data,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_event_valid,
    output logic [mbdeq_pkg::EVIDX_W-1:0]    o_event_input,
    output logic                             o_event_pressed,
    output logic [mbdeq_pkg::DROP_W-1:0]     o_dropped_count
);
    import mbdeq_pkg::*;

    // configuration
    logic [TICK_W-1:0] r_ticks;

    // per-input state
    logic              r_raw    [NUM_INPUTS];
    logic              r_stable [NUM_INPUTS];
    logic [TICK_W-1:0] r_since  [NUM_INPUTS];
    logic              r_primed;

    // scan walk
    logic [IDX_W-1:0]  r_idx;
    logic [PIN_W-1:0]  r_pins;

    // event ring
    t_event            r_mem [QUEUE_DEPTH];
    t_event            r_rd_data;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;

    // result staging
    logic              r_res_ev;
    t_event            r_res_event;
    logic [DROP_W-1:0] r_res_drop;

    // step logic signals
    logic [IDX_W+2:0]  w_idx_x;
    logic              w_pin;
    logic [TICK_W-1:0] w_since_new;
    logic              w_raise;
    logic [PTR_W-1:0]  w_wr_next;
    logic [PTR_W-1:0]  w_rd_next;
    logic              w_full;
    logic              w_empty;
    logic              w_push;
    t_event            w_new_event;

    // current pin, inputs past the pin field read released
    assign w_idx_x = {3'b000, r_idx};
    assign w_pin   = (w_idx_x < (IDX_W+3)'(PIN_W)) ? r_pins[w_idx_x[2:0]] : 1'b1;

    // saturating scan count since the raw level moved
    always_comb begin
        if (w_pin != r_raw[r_idx]) begin
            w_since_new = '0;
        end else if (r_since[r_idx] != SINCE_MAX) begin
            w_since_new = r_since[r_idx] + TICK_W'(1);
        end else begin
            w_since_new = r_since[r_idx];
        end
    end

    assign w_raise = r_primed && (w_pin != r_stable[r_idx]) && (w_since_new >= r_ticks);

    // ring pointers
    assign w_wr_next = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
    assign w_rd_next = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
    assign w_full    = (w_wr_next == r_rd_ptr);
    assign w_empty   = (r_rd_ptr == r_wr_ptr);
    assign w_push    = i_cmd.step && w_raise && !w_full;

    assign w_new_event.ev_index   = w_idx_x[EVIDX_W-1:0];
    assign w_new_event.ev_pressed = ~w_pin;

    // status back to the controller
    assign o_sts.last_idx = (r_idx == IDX_W'(NUM_INPUTS - 1));
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= DEBOUNCE_RESET;
            r_primed    <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < NUM_INPUTS; k++) begin
                r_raw[k]    <= 1'b0;
                r_stable[k] <= 1'b0;
                r_since[k]  <= '0;
            end
        end else begin
            // register write
            if (i_cfg_valid) begin
                r_ticks <= i_cfg_data;
            end
            // word accepted, restart the walk
            if (i_cmd.start) begin
                r_idx <= '0;
            end
            // one input per cycle
            if (i_cmd.step) begin
                r_idx <= r_idx + IDX_W'(1);
                r_raw[r_idx] <= w_pin;
                if (!r_primed) begin
                    r_stable[r_idx] <= w_pin;
                    r_since[r_idx]  <= '0;
                end else begin
                    r_since[r_idx] <= w_since_new;
                    if (w_raise) begin
                        r_stable[r_idx] <= w_pin;
                    end
                end
                if (o_sts.last_idx) begin
                    r_primed <= 1'b1;
                end
            end
            if (w_push) begin
                r_wr_ptr <= w_wr_next;
            end
            // pop oldest event
            if (i_cmd.pop && !w_empty) begin
                r_rd_ptr <= w_rd_next;
            end
            // output register handshake
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // ring memory, registered read at the head
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_new_event;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // payload: pins, result staging and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pins      <= i_pin_levels;
            r_res_ev    <= 1'b0;
            r_res_event <= '0;
            r_res_drop  <= '0;
        end
        if (i_cmd.step && w_raise && w_full && (r_res_drop != DROP_MAX)) begin
            r_res_drop <= r_res_drop + DROP_W'(1);
        end
        if (i_cmd.pop && !w_empty) begin
            r_res_ev    <= 1'b1;
            r_res_event <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            o_event_valid   <= r_res_ev;
            o_event_input   <= r_res_event.ev_index;
            o_event_pressed <= r_res_event.ev_pressed;
            o_dropped_count <= r_res_drop;
        end
    end

endmodule
`default_nettype wire

/* src/multi_button_debounce_event_queue_top.sv */
// Button debouncer with event queue.
// Input channel (i_in_valid / o_in_ready) takes one word: i_cmd selects a
// scan (pin levels in i_pin_levels, low = pressed) or a pop of the oldest
// event. Every word gives exactly one result word on the output channel
// (o_out_valid / i_out_ready): a scan reports o_dropped_count, a pop reports
// o_event_valid, o_event_input and o_event_pressed.
// The config channel (i_cfg_valid / o_cfg_ready, ready whenever out of reset)
// writes the debounce threshold in scans; write it only while the block is idle.
// A scan walks the inputs one per cycle through a single debounce datapath;
// a pop reads the ring head from a registered memory port. A new word is
// taken only after the last result is loaded; one finished result may wait in
// the output register while the next word is processed, and the block only
// holds in its result step if that register is still full.
// Reset clears pointers, debounce state and the threshold (back to 20); the
// first scan after reset just loads pin levels and raises no events.
// ----------------------------------------------------------------------------
// multi_button_debounce_event_queue_top
// top level joining the sequencer and the debounce/queue datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module multi_button_debounce_event_queue_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input words
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_cmd,
    input  wire [mbdeq_pkg::PIN_W-1:0]       i_pin_levels,
    // result words
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_event_valid,
    output logic [mbdeq_pkg::EVIDX_W-1:0]    o_event_input,
    output logic                             o_event_pressed,
    output logic [mbdeq_pkg::DROP_W-1:0]     o_dropped_count,
    // threshold register
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [mbdeq_pkg::TICK_W-1:0]      i_cfg_data
);
    import mbdeq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // register writes are taken only out of reset
    assign o_cfg_ready = i_rst_n;

    // sequencer
    mbdeq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // debounce and queue datapath
    mbdeq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_pin_levels    (i_pin_levels),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_event_valid   (o_event_valid),
        .o_event_input   (o_event_input),
        .o_event_pressed (o_event_pressed),
        .o_dropped_count (o_dropped_count)
    );

    // checks
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, w_cmd.load_out, w_sts.out_free)
    `ASSERT_IMPL(a_one_kind, i_clk, i_rst_n, o_out_valid, !(o_event_valid && (o_dropped_count != '0)))
    `ASSERT_IMPL(a_no_step_and_pop, i_clk, i_rst_n, w_cmd.step, !w_cmd.pop && !w_cmd.start)

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the button debouncer with event queue
//
// Scan and pop words are queued up front per phase and driven on the falling
// edge with random gaps, while the result side stalls at random. Each taken
// word is run through a local debounce and ring-queue predictor, and every
// result word is checked field by field against the oldest prediction. The
// threshold register is rewritten between phases once the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
    import mbdeq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;

    // one input word
    typedef struct packed {
        logic             cmd;
        logic [PIN_W-1:0] pins;
    } t_word;

    // one result word
    typedef struct packed {
        logic               ev_valid;
        logic [EVIDX_W-1:0] ev_input;
        logic               ev_pressed;
        logic [DROP_W-1:0]  dropped;
    } t_result;

    // bench-side drive
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_cmd    = CMD_SCAN;
    logic [PIN_W-1:0]  in_pins   = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [TICK_W-1:0] cfg_data  = '0;

    // block outputs
    wire               in_ready;
    wire               out_valid;
    wire               ev_valid;
    wire [EVIDX_W-1:0] ev_input;
    wire               ev_pressed;
    wire [DROP_W-1:0]  dropped;
    wire               cfg_ready;

    // stimulus and scoreboard
    t_word   words_to_send [$];
    t_result reports_due [$];
    logic    in_taken = 1'b0;
    int      send_idle_pct = 31;
    int      recv_idle_pct = 31;
    int      fail_count = 0;
    int      quiet_cycles = 0;
    logic [PIN_W-1:0] held_pins;

    // predictor state
    logic              raw_lvl [NUM_INPUTS];
    logic              stable_lvl [NUM_INPUTS];
    logic [TICK_W-1:0] since_cnt [NUM_INPUTS];
    logic              primed;
    t_event            ev_ring [QUEUE_DEPTH];
    int                rd_ptr;
    int                wr_ptr;
    logic [TICK_W-1:0] deb_ticks;

    multi_button_debounce_event_queue_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_cmd           (in_cmd),
        .i_pin_levels    (in_pins),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_valid   (ev_valid),
        .o_event_input   (ev_input),
        .o_event_pressed (ev_pressed),
        .o_dropped_count (dropped),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // debounce one scan or pop one event, returning the expected result word
    function automatic t_result debounce_step(t_word w);
        t_result           r;
        logic              p;
        int                i;
        int                nxt;
        logic [DROP_W-1:0] drops;
        r = '0;
        drops = '0;
        if (w.cmd == CMD_POP) begin
            if (rd_ptr != wr_ptr) begin
                r.ev_valid   = 1'b1;
                r.ev_input   = ev_ring[rd_ptr].ev_index;
                r.ev_pressed = ev_ring[rd_ptr].ev_pressed;
                rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
            end
            return r;
        end
        // first scan after reset only loads the levels
        if (!primed) begin
            for (i = 0; i < NUM_INPUTS; i++) begin
                p = (i < PIN_W) ? w.pins[i] : 1'b1;
                raw_lvl[i]    = p;
                stable_lvl[i] = p;
                since_cnt[i]  = '0;
            end
            primed = 1'b1;
            return r;
        end
        for (i = 0; i < NUM_INPUTS; i++) begin
            p = (i < PIN_W) ? w.pins[i] : 1'b1;
            if (p != raw_lvl[i]) begin
                raw_lvl[i]   = p;
                since_cnt[i] = '0;
            end else if (since_cnt[i] != SINCE_MAX) begin
                since_cnt[i] = since_cnt[i] + 1'b1;
            end
            if (p != stable_lvl[i] && since_cnt[i] >= deb_ticks) begin
                stable_lvl[i] = p;
                nxt = (wr_ptr + 1) % QUEUE_DEPTH;
                if (nxt != rd_ptr) begin
                    ev_ring[wr_ptr] = '{ev_index: EVIDX_W'(i), ev_pressed: ~p};
                    wr_ptr = nxt;
                end else if (drops != DROP_MAX) begin
                    drops = drops + 1'b1;
                end
            end
        end
        r.dropped = drops;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
    endtask

    // button activity: held levels that change now and then, with one-scan
    // glitches and pops mixed in
    task automatic gen_words(input int count, input int chg_pct, input int bounce_pct,
                             input int pop_pct);
        int               k;
        logic [PIN_W-1:0] v;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < pop_pct) begin
                words_to_send.push_back('{cmd: CMD_POP, pins: PIN_W'($urandom)});
            end else begin
                if ($urandom_range(99) < chg_pct) begin
                    if ($urandom_range(3) == 0)
                        held_pins = PIN_W'($urandom);
                    else
                        held_pins ^= PIN_W'(1) << $urandom_range(PIN_W-1);
                end
                v = held_pins;
                if ($urandom_range(99) < bounce_pct)
                    v ^= PIN_W'(1) << $urandom_range(PIN_W-1);
                words_to_send.push_back('{cmd: CMD_SCAN, pins: v});
            end
        end
    endtask

    task automatic push_word(input logic cmd, input logic [PIN_W-1:0] pins);
        words_to_send.push_back('{cmd: cmd, pins: pins});
    endtask

    // hold the sender until every outstanding result is back
    task automatic drain();
        while (words_to_send.size() != 0 || in_valid || reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TICK_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // word driver
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!in_valid || in_taken) begin
            if (rst_n && words_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_cmd   <= words_to_send[0].cmd;
                in_pins  <= words_to_send[0].pins;
                void'(words_to_send.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: check results, then predict for taken words
    always @(posedge clk) begin : watch_ports
        t_result got;
        t_result want;
        in_taken = 1'b0;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = '{ev_valid: ev_valid, ev_input: ev_input, ev_pressed: ev_pressed,
                        dropped: dropped};
                if (reports_due.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, got);
                    fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    if (got.ev_valid !== want.ev_valid)
                        report_field("event_valid", want.ev_valid, got.ev_valid);
                    if (got.ev_input !== want.ev_input)
                        report_field("event_input", want.ev_input, got.ev_input);
                    if (got.ev_pressed !== want.ev_pressed)
                        report_field("event_pressed", want.ev_pressed, got.ev_pressed);
                    if (got.dropped !== want.dropped)
                        report_field("dropped_count", want.dropped, got.dropped);
                end
            end
            if (cfg_valid && cfg_ready)
                deb_ticks = cfg_data;
            if (in_valid && in_ready) begin
                in_taken = 1'b1;
                reports_due.push_back(debounce_step('{cmd: in_cmd, pins: in_pins}));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("multi_button_debounce_event_queue_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // phases
    initial begin : run_phases
        int i;
        for (i = 0; i < NUM_INPUTS; i++) begin
            raw_lvl[i]    = 1'b0;
            stable_lvl[i] = 1'b0;
            since_cnt[i]  = '0;
        end
        primed    = 1'b0;
        rd_ptr    = 0;
        wr_ptr    = 0;
        deb_ticks = DEBOUNCE_RESET;
        held_pins = PIN_W'($urandom);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset threshold: priming scan, pops on an empty queue, extreme pins
        push_word(CMD_SCAN, 8'hA5);
        push_word(CMD_POP, 8'h00);
        push_word(CMD_SCAN, 8'h00);
        push_word(CMD_SCAN, 8'hFF);
        push_word(CMD_POP, 8'hFF);
        gen_words(220, 3, 5, 15);

        // zero threshold: every flip of all pins is an event, queue overflows
        write_threshold(8'd0);
        push_word(CMD_SCAN, 8'h00);
        push_word(CMD_SCAN, 8'hFF);
        push_word(CMD_SCAN, 8'h00);
        push_word(CMD_SCAN, 8'hFF);
        push_word(CMD_SCAN, 8'h00);
        repeat (4) push_word(CMD_POP, 8'h5A);
        held_pins = 8'h00;
        gen_words(150, 30, 10, 45);

        // minimum threshold, then a stretch with no gaps on either side
        write_threshold(8'd1);
        gen_words(150, 20, 10, 35);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_words(200, 20, 10, 35);
        drain();
        send_idle_pct = 31;
        recv_idle_pct = 31;

        // maximum threshold: one change held past the saturating count
        write_threshold(8'd255);
        held_pins = ~held_pins;
        gen_words(300, 0, 0, 3);
        repeat (12) push_word(CMD_POP, PIN_W'($urandom));

        // small threshold: fill the queue without pops, drain, then mixed use
        write_threshold(8'd3);
        gen_words(80, 40, 0, 0);
        gen_words(40, 0, 0, 100);
        gen_words(300, 10, 15, 30);

        // noisy pins
        write_threshold(8'd2);
        gen_words(150, 100, 30, 40);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("multi_button_debounce_event_queue_top regression: pass");
        else
            $display("multi_button_debounce_event_queue_top regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/mbdeq_pkg.sv
src/mbdeq_ctrl.sv
src/mbdeq_datapath.sv
src/multi_button_debounce_event_queue_top.sv
test/tb_top.sv
